[rtl/button_state_message_parser_macros.svh]
// ----------------------------------------------------------------------------
// Button state message parser assertion macros
// Concurrent assertion forms used by the parser controller.
// ----------------------------------------------------------------------------
`ifndef BUTTON_STATE_MESSAGE_PARSER_MACROS_SVH
`define BUTTON_STATE_MESSAGE_PARSER_MACROS_SVH

// The condition must never hold outside reset.
`define BSMP_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: condition must never hold");

// When the trigger holds, the consequence must hold in the next cycle.
`define BSMP_ASSERT_NEXT(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("assertion failed: expected consequence one cycle later");

`endif

[rtl/bsmp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button state message parser package
// Constants, codes, prefix tables and control structures of the parser.
// ----------------------------------------------------------------------------
package bsmp_pkg;

  localparam int NAME_MAX = 32;
  localparam int NAME_CAP = ((NAME_MAX - 1) > 31) ? 31 : (NAME_MAX - 1);
  localparam int IDX_W    = (NAME_CAP > 1) ? $clog2(NAME_CAP) : 1;
  localparam int CNT_W    = $clog2(NAME_CAP + 1);

  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int BTN_W  = 2;
  localparam int SEQ_W  = 32;
  localparam int LEN_W  = 5;
  localparam int POS_W  = 3;

  localparam int BTN_LEN       = 4;
  localparam int STATE_PFX_LEN = 6;

  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_COLON   = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;

  typedef enum logic [KIND_W-1:0] {
    KIND_INVALID = 2'd0,
    KIND_BUTTON  = 2'd1,
    KIND_STATE   = 2'd2
  } kind_t;

  typedef enum logic [7:0] {
    PH_START     = 8'b0000_0001,
    PH_BTN_PFX   = 8'b0000_0010,
    PH_STATE_PFX = 8'b0000_0100,
    PH_ID        = 8'b0000_1000,
    PH_SEQ       = 8'b0001_0000,
    PH_SEQ_DONE  = 8'b0010_0000,
    PH_NAME      = 8'b0100_0000,
    PH_BAD       = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic take;
    logic load_head;
    logic load_name;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic out_last;
  } dp_status_t;

  function automatic logic [BYTE_W-1:0] btn_prefix_char(input logic [POS_W-1:0] pos);
    logic [BYTE_W-1:0] c;
    case (pos)
      3'd0:    c = 8'h42;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h4E;
      3'd3:    c = CH_COLON;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] state_prefix_char(input logic [POS_W-1:0] pos);
    logic [BYTE_W-1:0] c;
    case (pos)
      3'd0:    c = 8'h53;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h41;
      3'd3:    c = 8'h54;
      3'd4:    c = 8'h45;
      3'd5:    c = CH_COLON;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/bsmp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button state message parser channels
// Valid/ready channels for message bytes in and parse results out.
// ----------------------------------------------------------------------------
interface bsmp_in_if;
  logic                         valid;
  logic                         ready;
  logic [bsmp_pkg::BYTE_W-1:0]  message_byte;
  logic                         final_byte;

  modport source(output valid, output message_byte, output final_byte, input ready);
  modport sink(input valid, input message_byte, input final_byte, output ready);
endinterface

interface bsmp_out_if;
  logic                         valid;
  logic                         ready;
  logic [bsmp_pkg::KIND_W-1:0]  kind;
  logic [bsmp_pkg::BTN_W-1:0]   button_number;
  logic [bsmp_pkg::SEQ_W-1:0]   sequence_number;
  logic [bsmp_pkg::LEN_W-1:0]   name_length;
  logic [bsmp_pkg::BYTE_W-1:0]  name_char;
  logic                         is_name_char;
  logic                         last_of_run;

  modport source(output valid, output kind, output button_number, output sequence_number,
                 output name_length, output name_char, output is_name_char,
                 output last_of_run, input ready);
  modport sink(input valid, input kind, input button_number, input sequence_number,
               input name_length, input name_char, input is_name_char,
               input last_of_run, output ready);
endinterface

[rtl/bsmp_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button state message parser datapath
// Parse registers, decimal accumulators, name memory and result register.
// ----------------------------------------------------------------------------
module bsmp_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  bsmp_pkg::dp_cmd_t             cmd,
  output bsmp_pkg::dp_status_t          status,
  input  logic [bsmp_pkg::BYTE_W-1:0]   message_byte,
  input  logic                          final_byte,
  output logic [bsmp_pkg::KIND_W-1:0]   kind,
  output logic [bsmp_pkg::BTN_W-1:0]    button_number,
  output logic [bsmp_pkg::SEQ_W-1:0]    sequence_number,
  output logic [bsmp_pkg::LEN_W-1:0]    name_length,
  output logic [bsmp_pkg::BYTE_W-1:0]   name_char,
  output logic                          is_name_char,
  output logic                          last_of_run
);

  bsmp_pkg::phase_t                 phase, phase_next;
  logic [bsmp_pkg::POS_W-1:0]       pos, pos_next;
  logic [bsmp_pkg::SEQ_W-1:0]       id_acc, id_acc_next;
  logic [bsmp_pkg::SEQ_W-1:0]       seq_acc, seq_acc_next;
  logic                             digit_seen, digit_seen_next;
  logic [bsmp_pkg::CNT_W-1:0]       name_count, name_count_next;
  logic [bsmp_pkg::CNT_W-1:0]       idx;
  logic [bsmp_pkg::CNT_W-1:0]       rd_addr;
  logic [bsmp_pkg::BYTE_W-1:0]      rd_data;
  logic [bsmp_pkg::BYTE_W-1:0]      name_mem [bsmp_pkg::NAME_CAP];

  logic                             parse_en;
  logic                             is_digit;
  logic [bsmp_pkg::SEQ_W-1:0]       digit_val;
  logic [bsmp_pkg::POS_W-1:0]       pos_inc;
  logic                             name_wr;
  logic                             btn_ok;
  logic                             state_ok;

  function automatic logic [bsmp_pkg::SEQ_W-1:0] mul10_add(
    input logic [bsmp_pkg::SEQ_W-1:0] acc,
    input logic [bsmp_pkg::SEQ_W-1:0] d
  );
    return (acc << 3) + (acc << 1) + d;
  endfunction

  assign parse_en  = cmd.take && !(final_byte && message_byte == bsmp_pkg::CH_NEWLINE);
  assign is_digit  = (message_byte >= bsmp_pkg::CH_ZERO) && (message_byte <= bsmp_pkg::CH_NINE);
  assign digit_val = bsmp_pkg::SEQ_W'(message_byte - bsmp_pkg::CH_ZERO);
  assign pos_inc   = pos + 3'd1;
  assign name_wr   = parse_en && phase == bsmp_pkg::PH_NAME &&
                     name_count < bsmp_pkg::CNT_W'(bsmp_pkg::NAME_CAP);

  always_comb begin
    phase_next      = phase;
    pos_next        = pos;
    id_acc_next     = id_acc;
    seq_acc_next    = seq_acc;
    digit_seen_next = digit_seen;
    name_count_next = name_count;
    if (parse_en) begin
      case (phase)
        bsmp_pkg::PH_START: begin
          if (message_byte == bsmp_pkg::btn_prefix_char(3'd0)) begin
            phase_next = bsmp_pkg::PH_BTN_PFX;
            pos_next   = 3'd1;
          end else if (message_byte == bsmp_pkg::state_prefix_char(3'd0)) begin
            phase_next = bsmp_pkg::PH_STATE_PFX;
            pos_next   = 3'd1;
          end else begin
            phase_next = bsmp_pkg::PH_BAD;
          end
        end
        bsmp_pkg::PH_BTN_PFX: begin
          if (pos < bsmp_pkg::POS_W'(bsmp_pkg::BTN_LEN) &&
              message_byte == bsmp_pkg::btn_prefix_char(pos)) begin
            pos_next = pos_inc;
            if (pos_inc == bsmp_pkg::POS_W'(bsmp_pkg::BTN_LEN)) begin
              phase_next      = bsmp_pkg::PH_ID;
              digit_seen_next = 1'b0;
            end
          end else begin
            phase_next = bsmp_pkg::PH_BAD;
          end
        end
        bsmp_pkg::PH_STATE_PFX: begin
          if (pos < bsmp_pkg::POS_W'(bsmp_pkg::STATE_PFX_LEN) &&
              message_byte == bsmp_pkg::state_prefix_char(pos)) begin
            pos_next = pos_inc;
            if (pos_inc == bsmp_pkg::POS_W'(bsmp_pkg::STATE_PFX_LEN)) begin
              phase_next      = bsmp_pkg::PH_NAME;
              name_count_next = '0;
            end
          end else begin
            phase_next = bsmp_pkg::PH_BAD;
          end
        end
        bsmp_pkg::PH_ID: begin
          if (is_digit) begin
            id_acc_next     = mul10_add(id_acc, digit_val);
            digit_seen_next = 1'b1;
          end else if (message_byte == bsmp_pkg::CH_COLON && digit_seen) begin
            phase_next      = bsmp_pkg::PH_SEQ;
            digit_seen_next = 1'b0;
          end else begin
            phase_next = bsmp_pkg::PH_BAD;
          end
        end
        bsmp_pkg::PH_SEQ: begin
          if (is_digit) begin
            seq_acc_next    = mul10_add(seq_acc, digit_val);
            digit_seen_next = 1'b1;
          end else begin
            phase_next = digit_seen ? bsmp_pkg::PH_SEQ_DONE : bsmp_pkg::PH_BAD;
          end
        end
        bsmp_pkg::PH_NAME: begin
          if (name_wr) begin
            name_count_next = name_count + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      phase      <= bsmp_pkg::PH_START;
      pos        <= '0;
      id_acc     <= '0;
      seq_acc    <= '0;
      digit_seen <= 1'b0;
      name_count <= '0;
    end else begin
      phase      <= phase_next;
      pos        <= pos_next;
      id_acc     <= id_acc_next;
      seq_acc    <= seq_acc_next;
      digit_seen <= digit_seen_next;
      name_count <= name_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (name_wr) begin
      name_mem[name_count[bsmp_pkg::IDX_W-1:0]] <= message_byte;
    end
  end

  // The read address runs one ahead on each name item so the next byte is ready.
  assign rd_addr = cmd.load_name ? idx + 1'b1 : idx;

  always_ff @(posedge clk) begin
    if (rd_addr < bsmp_pkg::CNT_W'(bsmp_pkg::NAME_CAP)) begin
      rd_data <= name_mem[rd_addr[bsmp_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      idx <= '0;
    end else if (cmd.load_name) begin
      idx <= idx + 1'b1;
    end
  end

  assign btn_ok   = ((phase == bsmp_pkg::PH_SEQ && digit_seen) ||
                     phase == bsmp_pkg::PH_SEQ_DONE) &&
                    (id_acc inside {32'd1, 32'd2});
  assign state_ok = phase == bsmp_pkg::PH_NAME && name_count != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_of_run <= 1'b0;
    end else if (cmd.load_head) begin
      last_of_run <= !state_ok;
    end else if (cmd.load_name) begin
      last_of_run <= (idx + 1'b1) == name_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_head) begin
      kind            <= btn_ok ? bsmp_pkg::KIND_BUTTON :
                         (state_ok ? bsmp_pkg::KIND_STATE : bsmp_pkg::KIND_INVALID);
      button_number   <= btn_ok ? id_acc[bsmp_pkg::BTN_W-1:0] : '0;
      sequence_number <= btn_ok ? seq_acc : '0;
      name_length     <= state_ok ? bsmp_pkg::LEN_W'(name_count) : '0;
      name_char       <= '0;
      is_name_char    <= 1'b0;
    end else if (cmd.load_name) begin
      kind            <= bsmp_pkg::KIND_STATE;
      button_number   <= '0;
      sequence_number <= '0;
      name_length     <= '0;
      name_char       <= rd_data;
      is_name_char    <= 1'b1;
    end
  end

  assign status.out_last = last_of_run;

endmodule

[rtl/bsmp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button state message parser controller
// Sequences byte intake, header result and name byte results.
// ----------------------------------------------------------------------------
`include "button_state_message_parser_macros.svh"

module bsmp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_final,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bsmp_pkg::dp_cmd_t     cmd,
  input  bsmp_pkg::dp_status_t  status
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FIN  = 4'b0010,
    ST_HEAD = 4'b0100,
    ST_NAME = 4'b1000
  } ctrl_state_t;

  ctrl_state_t state, state_next;
  logic        in_acc;
  logic        out_acc;

  assign in_ready  = state == ST_IDLE;
  assign out_valid = state == ST_HEAD || state == ST_NAME;
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  assign cmd.take      = in_acc;
  assign cmd.load_head = state == ST_FIN;
  assign cmd.load_name = out_acc && !status.out_last;
  assign cmd.clear     = out_acc && status.out_last;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && in_final) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        state_next = ST_HEAD;
      end
      ST_HEAD, ST_NAME: begin
        if (out_acc) begin
          state_next = status.out_last ? ST_IDLE : ST_NAME;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `BSMP_ASSERT_NEVER(a_no_overlap, clk, rst, in_ready && out_valid)
  `BSMP_ASSERT_NEXT(a_final_stops_input, clk, rst, in_acc && in_final, !in_ready && !out_valid)
  `BSMP_ASSERT_NEXT(a_head_shown, clk, rst, cmd.load_head, out_valid)
  `BSMP_ASSERT_NEXT(a_run_end_idle, clk, rst, cmd.clear, in_ready && !out_valid)

endmodule

[rtl/button_state_message_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button state message parser
// Parses "BTN:<id>:<seq>" and "STATE:<name>" text messages, one byte per item.
// ----------------------------------------------------------------------------
// The message channel takes one byte per item, with final_byte set on the
// last byte of a message. Bytes are taken at one per cycle while no results
// are pending. A trailing newline on the final byte is dropped.
// After the final byte the block forms the header in its ST_FIN state, then
// shows the header item on the result channel. A state message follows it
// with one item per stored name byte, the last marked by last_of_run.
// While results are pending the message channel is not ready. When the
// receiver holds ready low, the current result item stays unchanged.
// Reset clears the parse state and the sequencer; the name memory is not
// cleared, and only bytes written in the current message are read out.
// ----------------------------------------------------------------------------
module button_state_message_parser (
  input  logic         clk,
  input  logic         rst,
  bsmp_in_if.sink      message,
  bsmp_out_if.source   result
);

  bsmp_pkg::dp_cmd_t    cmd;
  bsmp_pkg::dp_status_t status;

  bsmp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (message.valid),
    .in_final  (message.final_byte),
    .in_ready  (message.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  bsmp_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .message_byte    (message.message_byte),
    .final_byte      (message.final_byte),
    .kind            (result.kind),
    .button_number   (result.button_number),
    .sequence_number (result.sequence_number),
    .name_length     (result.name_length),
    .name_char       (result.name_char),
    .is_name_char    (result.is_name_char),
    .last_of_run     (result.last_of_run)
  );

endmodule
